### src/rvdec_pkg.sv
// rv32i decoder package: opcodes, control codes and the control word type
`default_nettype none

package rvdec_pkg;

	localparam int unsigned IN_W  = 64;
	localparam int unsigned OUT_W = 112;

	localparam logic [6:0] OPC_REG    = 7'b0110011;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;

	localparam logic [3:0] ALU_ADD = 4'd1;
	localparam logic [3:0] ALU_SUB = 4'd2;
	localparam logic [3:0] ALU_AND = 4'd3;
	localparam logic [3:0] ALU_OR  = 4'd4;
	localparam logic [3:0] ALU_SLL = 4'd5;
	localparam logic [3:0] ALU_SLT = 4'd6;
	localparam logic [3:0] ALU_SRA = 4'd7;
	localparam logic [3:0] ALU_SRL = 4'd8;
	localparam logic [3:0] ALU_XOR = 4'd9;

	localparam logic [1:0] OP2_RS2  = 2'd0;
	localparam logic [1:0] OP2_IMMI = 2'd1;
	localparam logic [1:0] OP2_IMMS = 2'd2;

	localparam logic [2:0] RES_PC4   = 3'd0;
	localparam logic [2:0] RES_UPPER = 3'd1;
	localparam logic [2:0] RES_LOAD  = 3'd2;
	localparam logic [2:0] RES_ALU   = 3'd3;
	localparam logic [2:0] RES_AUIPC = 3'd4;

	localparam logic [1:0] NPC_ALU    = 2'd0;
	localparam logic [1:0] NPC_TARGET = 2'd1;
	localparam logic [1:0] NPC_PC4    = 2'd2;

	localparam logic [3:0] FLAG_RW  = 4'b0001;
	localparam logic [3:0] FLAG_MW  = 4'b0010;
	localparam logic [3:0] FLAG_BR  = 4'b0100;
	localparam logic [3:0] FLAG_ILL = 4'b1000;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SHR  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	typedef struct packed {
		logic [3:0] ctrl_flags;
		logic [1:0] next_pc_sel;
		logic [2:0] result_sel;
		logic [1:0] op2_sel;
		logic [3:0] alu_op;
	} ctrl_t;

endpackage

`default_nettype wire

### src/rv32i_instruction_decoder_unit.sv
// rv32i instruction decoder, three-stage pipeline with stream ports
// a word accepted on s_tdata passes through the stage 1, 2 and 3 registers to m_tdata
// throughput: one word per cycle; each stage holds only while its successor is full
// stage 1 registers the word, stage 2 decodes control and immediates,
// stage 3 forms the jump target and auipc sums
// reset clears all valid bits, payload registers are not reset
`default_nettype none

module rv32i_instruction_decoder_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// instr [31:0], pc [63:32]
	input  wire  [rvdec_pkg::IN_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire                         m_tready,
	// alu_op, op2_sel, result_sel, next_pc_sel, ctrl_flags, funct3, rs1_index,
	// rs2_index, rd_index, op2_immediate, jump_target, auipc_sum, zero pad
	output logic [rvdec_pkg::OUT_W-1:0] m_tdata
);
	import rvdec_pkg::*;

	logic        valid_s1, valid_s2, valid_s3;
	logic        rdy1, rdy2, rdy3;
	logic [31:0] instr_s1, pc_s1;

	ctrl_t       ctrl_s2, ctrl_s3;
	logic [2:0]  f3_s2, f3_s3;
	logic [4:0]  rs1_s2, rs1_s3, rs2_s2, rs2_s3, rd_s2, rd_s3;
	logic [11:0] imm_s2, imm_s3;
	logic [31:0] pc_s2, ofs_s2, upper_s2;
	logic [31:0] target_s3, auipc_s3;

	ctrl_t       ctrl_d;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic        f7_nz;
	logic [3:0]  alu_fn;
	logic [31:0] imm_b, imm_j;

	assign rdy3     = !valid_s3 || m_tready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	// stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			instr_s1 <= s_tdata[31:0];
			pc_s1    <= s_tdata[63:32];
		end
	end

	// decode
	assign opc   = instr_s1[6:0];
	assign f3    = instr_s1[14:12];
	assign f7_nz = |instr_s1[31:25];
	assign imm_b = {{19{instr_s1[31]}}, instr_s1[31], instr_s1[7], instr_s1[30:25],
		instr_s1[11:8], 1'b0};
	assign imm_j = {{11{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
		instr_s1[30:21], 1'b0};

	always_comb begin
		unique case (f3)
			F3_ADD:  alu_fn = (opc == OPC_REG && f7_nz) ? ALU_SUB : ALU_ADD;
			F3_SLL:  alu_fn = ALU_SLL;
			F3_SLT:  alu_fn = ALU_SLT;
			F3_XOR:  alu_fn = ALU_XOR;
			F3_SHR:  alu_fn = f7_nz ? ALU_SRA : ALU_SRL;
			F3_OR:   alu_fn = ALU_OR;
			F3_AND:  alu_fn = ALU_AND;
			default: alu_fn = ALU_ADD;
		endcase
	end

	always_comb begin
		ctrl_d.alu_op      = ALU_ADD;
		ctrl_d.op2_sel     = OP2_RS2;
		ctrl_d.result_sel  = RES_PC4;
		ctrl_d.next_pc_sel = NPC_PC4;
		ctrl_d.ctrl_flags  = FLAG_ILL;
		unique case (opc)
			OPC_REG: begin
				ctrl_d.ctrl_flags = FLAG_RW;
				ctrl_d.alu_op     = alu_fn;
				ctrl_d.result_sel = RES_ALU;
			end
			OPC_IMM: begin
				ctrl_d.ctrl_flags = FLAG_RW;
				ctrl_d.alu_op     = alu_fn;
				ctrl_d.op2_sel    = OP2_IMMI;
				ctrl_d.result_sel = RES_ALU;
			end
			OPC_LOAD: begin
				ctrl_d.ctrl_flags = FLAG_RW;
				ctrl_d.op2_sel    = OP2_IMMI;
				ctrl_d.result_sel = RES_LOAD;
			end
			OPC_JALR: begin
				ctrl_d.ctrl_flags  = FLAG_RW;
				ctrl_d.op2_sel     = OP2_IMMI;
				ctrl_d.next_pc_sel = NPC_ALU;
			end
			OPC_STORE: begin
				ctrl_d.ctrl_flags = FLAG_MW;
				ctrl_d.op2_sel    = OP2_IMMS;
			end
			OPC_BRANCH: begin
				ctrl_d.ctrl_flags = FLAG_BR;
				ctrl_d.alu_op     = ALU_SUB;
			end
			OPC_LUI: begin
				ctrl_d.ctrl_flags = FLAG_RW;
				ctrl_d.result_sel = RES_UPPER;
			end
			OPC_AUIPC: begin
				ctrl_d.ctrl_flags = FLAG_RW;
				ctrl_d.result_sel = RES_AUIPC;
			end
			OPC_JAL: begin
				ctrl_d.ctrl_flags  = FLAG_RW;
				ctrl_d.next_pc_sel = NPC_TARGET;
			end
			default: begin
				ctrl_d.ctrl_flags = FLAG_ILL;
			end
		endcase
	end

	// stage 2: control word, fields and immediates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			ctrl_s2  <= ctrl_d;
			f3_s2    <= f3;
			rs1_s2   <= instr_s1[19:15];
			rs2_s2   <= instr_s1[24:20];
			rd_s2    <= instr_s1[11:7];
			imm_s2   <= (opc == OPC_STORE) ? {instr_s1[31:25], instr_s1[11:7]}
				: instr_s1[31:20];
			pc_s2    <= pc_s1;
			ofs_s2   <= (opc == OPC_JAL) ? imm_j : imm_b;
			upper_s2 <= {instr_s1[31:12], 12'b0};
		end
	end

	// stage 3: address sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			ctrl_s3   <= ctrl_s2;
			f3_s3     <= f3_s2;
			rs1_s3    <= rs1_s2;
			rs2_s3    <= rs2_s2;
			rd_s3     <= rd_s2;
			imm_s3    <= imm_s2;
			target_s3 <= pc_s2 + ofs_s2;
			auipc_s3  <= pc_s2 + upper_s2;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {3'b000, auipc_s3, target_s3, imm_s3, rd_s3, rs2_s3, rs1_s3, f3_s3,
		ctrl_s3.ctrl_flags, ctrl_s3.next_pc_sel, ctrl_s3.result_sel, ctrl_s3.op2_sel,
		ctrl_s3.alu_op};

endmodule

`default_nettype wire

### src/rvdec_checker.sv
// port checker for the rv32i decoder and its bind
`default_nettype none

module rvdec_port_checks (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire [rvdec_pkg::OUT_W-1:0]  m_tdata
);
	import rvdec_pkg::*;

	// stalled output word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under stall");

	// pad bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[111:109] == 3'b000)
		else $error("pad bits nonzero");

	// exactly one control flag per decoded word
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tdata[14:11]))
		else $error("control flags not one-hot");

	// illegal opcode keeps default controls
	a_ill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[3:0] == ALU_ADD && m_tdata[5:4] == OP2_RS2
		&& m_tdata[8:6] == RES_PC4 && m_tdata[10:9] == NPC_PC4)
		else $error("illegal opcode with non-default controls");

	// jal writes pc+4 into rd
	a_jal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10:9] == NPC_TARGET |-> m_tdata[8:6] == RES_PC4
		&& m_tdata[14:11] == FLAG_RW)
		else $error("jump without link write");

endmodule

bind rv32i_instruction_decoder_unit rvdec_port_checks u_rvdec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
